// ===== src/rdcu_pkg.sv =====
package rdcu_pkg;

  localparam int CELL_W = 32;
  localparam int CONC_W = 16;
  localparam int U_SUM_W = 19;
  localparam int V_SUM_W = 20;
  localparam int CENTER_V_SHIFT = 13;
  localparam int RATE_SHIFT = 10;

  // floor(x/5) = (x*419431)>>21 for x < 2^19
  localparam logic [18:0] DIV5_MUL = 19'd419431;
  localparam int DIV5_SHIFT = 21;
  // floor(y/3) = (y*174763)>>19 for y < 2^18
  localparam logic [17:0] DIV3_MUL = 18'd174763;
  localparam int DIV3_SHIFT = 19;

  localparam logic [1:0] STENCIL_EVEN = 2'd0;
  localparam logic [1:0] STENCIL_NS = 2'd1;
  localparam logic [1:0] STENCIL_EW = 2'd2;

  localparam logic [1:0] RMODE_STD = 2'd0;
  localparam logic [1:0] RMODE_FAST = 2'd1;
  localparam logic [1:0] RMODE_LOWFEED = 2'd2;
  localparam logic [1:0] RMODE_WEAK = 2'd3;

  localparam logic [6:0] KILL_RATE = 7'd80;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [CONC_W-1:0] conc_t;
  typedef logic [1:0] rmode_t;

  typedef struct packed {
    conc_t u;
    conc_t v;
  } blur_t;

  typedef struct packed {
    logic [4:0] fk;
    logic [2:0] mu;
    logic [2:0] mv;
  } rates_t;

  typedef struct packed {
    cell_t new_cell;
    logic [7:0] display_level;
  } result_t;

  function automatic rates_t rates_of(input rmode_t mode);
    rates_t r;
    unique case (mode)
      RMODE_STD: r = '{fk: 5'd28, mu: 3'd2, mv: 3'd3};
      RMODE_FAST: r = '{fk: 5'd28, mu: 3'd4, mv: 3'd4};
      RMODE_LOWFEED: r = '{fk: 5'd27, mu: 3'd3, mv: 3'd3};
      RMODE_WEAK: r = '{fk: 5'd27, mu: 3'd2, mv: 3'd2};
      default: r = '{fk: 5'd27, mu: 3'd2, mv: 3'd2};
    endcase
    return r;
  endfunction

endpackage

// ===== src/rdcu_in_if.sv =====
interface rdcu_in_if;
  logic valid;
  logic ready;
  logic [31:0] center_cell;
  logic [31:0] north_cell;
  logic [31:0] south_cell;
  logic [31:0] east_cell;
  logic [31:0] west_cell;
  logic [1:0] stencil_mode;

  modport source (
    output valid, center_cell, north_cell, south_cell, east_cell, west_cell, stencil_mode,
    input ready
  );
  modport sink (
    input valid, center_cell, north_cell, south_cell, east_cell, west_cell, stencil_mode,
    output ready
  );
endinterface

// ===== src/rdcu_out_if.sv =====
interface rdcu_out_if;
  logic valid;
  logic ready;
  logic [31:0] new_cell;
  logic [7:0] display_level;

  modport source (output valid, new_cell, display_level, input ready);
  modport sink (input valid, new_cell, display_level, output ready);
endinterface

// ===== src/rdcu_cfg_if.sv =====
interface rdcu_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] reaction_mode;

  modport source (output valid, reaction_mode, input ready);
  modport sink (input valid, reaction_mode, output ready);
endinterface

// ===== src/rdcu_blur.sv =====
module rdcu_blur
  import rdcu_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  cell_t  center_cell,
  input  cell_t  north_cell,
  input  cell_t  south_cell,
  input  cell_t  east_cell,
  input  cell_t  west_cell,
  input  logic [1:0] stencil_mode,
  output logic   dn_valid,
  input  logic   dn_ready,
  output blur_t  dn_data
);

  logic s1_valid_r, s2_valid_r;
  logic en1, en2;

  logic [U_SUM_W-1:0] uc, un, us, ue, uw;
  logic [U_SUM_W-1:0] u_sum_nxt;
  logic div5_nxt;
  logic [V_SUM_W-1:0] v_sum_nxt;

  logic [U_SUM_W-1:0] s1_u_sum_r;
  logic s1_div5_r;
  logic [V_SUM_W-1:0] s1_v_sum_r;

  logic [U_SUM_W+19-1:0] prod5;
  logic [V_SUM_W-2+18-1:0] prod3;
  blur_t blur_nxt, s2_blur_r;

  assign en2 = !s2_valid_r || dn_ready;
  assign en1 = !s1_valid_r || en2;
  assign up_ready = en1;

  always_comb begin
    uc = U_SUM_W'(center_cell[CONC_W-1:0]);
    un = U_SUM_W'(north_cell[CONC_W-1:0]);
    us = U_SUM_W'(south_cell[CONC_W-1:0]);
    ue = U_SUM_W'(east_cell[CONC_W-1:0]);
    uw = U_SUM_W'(west_cell[CONC_W-1:0]);
    unique case (stencil_mode)
      STENCIL_NS: begin
        u_sum_nxt = ((uc + un + us) << 1) + ue + uw;
        div5_nxt = 1'b0;
      end
      STENCIL_EW: begin
        u_sum_nxt = ((uc + ue + uw) << 1) + un + us;
        div5_nxt = 1'b0;
      end
      default: begin
        u_sum_nxt = uc + un + us + ue + uw;
        div5_nxt = 1'b1;
      end
    endcase
    v_sum_nxt = V_SUM_W'(center_cell[CELL_W-1:CENTER_V_SHIFT])
              + V_SUM_W'(north_cell[CELL_W-1:CONC_W])
              + V_SUM_W'(south_cell[CELL_W-1:CONC_W])
              + V_SUM_W'(east_cell[CELL_W-1:CONC_W])
              + V_SUM_W'(west_cell[CELL_W-1:CONC_W]);
  end

  // reciprocal multiply for /5 and /12; the weighted stencils divide u by 8 with a shift
  always_comb begin
    prod5 = (U_SUM_W+19)'(s1_u_sum_r) * (U_SUM_W+19)'(DIV5_MUL);
    prod3 = (V_SUM_W-2+18)'(s1_v_sum_r[V_SUM_W-1:2]) * (V_SUM_W-2+18)'(DIV3_MUL);
    if (s1_div5_r) begin
      blur_nxt.u = prod5[DIV5_SHIFT +: CONC_W];
    end else begin
      blur_nxt.u = s1_u_sum_r[U_SUM_W-1:3];
    end
    blur_nxt.v = prod3[DIV3_SHIFT +: CONC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= up_valid;
      if (en2) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_u_sum_r <= u_sum_nxt;
      s1_div5_r <= div5_nxt;
      s1_v_sum_r <= v_sum_nxt;
    end
    if (en2) begin
      s2_blur_r <= blur_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_data = s2_blur_r;

endmodule

// ===== src/rdcu_react.sv =====
module rdcu_react
  import rdcu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  rmode_t  reaction_mode,
  input  logic    up_valid,
  output logic    up_ready,
  input  blur_t   up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output result_t dn_data
);

  logic a_valid_r, b_valid_r, c_valid_r;
  logic en_a, en_b, en_c;
  rates_t rates;

  logic [2*CONC_W-1:0] uv_prod;
  logic [20:0] feed_prod;
  logic [22:0] kill_prod;

  conc_t a_u_r, a_v_r, a_uv_r;
  logic [10:0] a_feed_r;
  logic [12:0] a_kill_r;

  logic [2*CONC_W-1:0] uvv_prod;
  conc_t b_u_r, b_v_r, b_uvv_r;
  logic [10:0] b_feed_r;
  logic [12:0] b_kill_r;

  logic signed [17:0] d_u, d_v;
  logic signed [20:0] du, dv, nu, nv;
  conc_t nu_c, nv_c;
  result_t res_nxt, c_res_r;

  assign en_c = !c_valid_r || dn_ready;
  assign en_b = !b_valid_r || en_c;
  assign en_a = !a_valid_r || en_b;
  assign up_ready = en_a;

  assign rates = rates_of(reaction_mode);

  always_comb begin
    uv_prod = (2*CONC_W)'(up_data.u) * (2*CONC_W)'(up_data.v);
    feed_prod = 21'(rates.fk) * 21'(16'hffff - up_data.u);
    kill_prod = 23'(KILL_RATE) * 23'(up_data.v);
  end

  assign uvv_prod = (2*CONC_W)'(a_uv_r) * (2*CONC_W)'(a_v_r);

  always_comb begin
    d_u = $signed({7'b0, b_feed_r}) - $signed({2'b0, b_uvv_r});
    d_v = $signed({2'b0, b_uvv_r}) - $signed({5'b0, b_kill_r});
    du = 21'(d_u) * $signed({18'b0, rates.mu});
    dv = 21'(d_v) * $signed({18'b0, rates.mv});
    nu = $signed({5'b0, b_u_r}) + du;
    nv = $signed({5'b0, b_v_r}) + dv;
    priority if (nu < 0) begin
      nu_c = '0;
    end else if (nu > $signed(21'hffff)) begin
      nu_c = 16'hffff;
    end else begin
      nu_c = nu[CONC_W-1:0];
    end
    priority if (nv < 0) begin
      nv_c = '0;
    end else if (nv > $signed(21'hffff)) begin
      nv_c = 16'hffff;
    end else begin
      nv_c = nv[CONC_W-1:0];
    end
    res_nxt.new_cell = {nv_c, nu_c};
    res_nxt.display_level = nu_c[CONC_W-1:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (en_a) a_valid_r <= up_valid;
      if (en_b) b_valid_r <= a_valid_r;
      if (en_c) c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_u_r <= up_data.u;
      a_v_r <= up_data.v;
      a_uv_r <= uv_prod[2*CONC_W-1:CONC_W];
      a_feed_r <= feed_prod[20:RATE_SHIFT];
      a_kill_r <= kill_prod[22:RATE_SHIFT];
    end
    if (en_b) begin
      b_u_r <= a_u_r;
      b_v_r <= a_v_r;
      b_uvv_r <= uvv_prod[2*CONC_W-1:CONC_W];
      b_feed_r <= a_feed_r;
      b_kill_r <= a_kill_r;
    end
    if (en_c) begin
      c_res_r <= res_nxt;
    end
  end

  assign dn_valid = c_valid_r;
  assign dn_data = c_res_r;

endmodule

// ===== src/reaction_diffusion_cell_update_top.sv =====
// Gray-Scott style cell update, one grid cell per beat.
// in_bus carries a cell and its four neighbours, each packed as u in bits 15..0
// and v in bits 31..16, plus the stencil mode; out_bus returns the new packed
// cell and an 8-bit display level (new u >> 8). Both use valid/ready.
// cfg_bus writes the 2-bit reaction mode (rate set); it is always ready. The
// user must write it only while the pipeline is empty; the block does not enforce this.
// From input beat to output valid the data passes five register stages: two
// stages form the blurred u and v (sums, then reciprocal multiply for /5 and
// /12, or a shift for /8), three stages do u*v, u*v*v with the feed and kill
// terms, then the rate step and clamp into the output register.
// Throughput is one beat per cycle unless the receiver stalls; each stage
// has its own valid bit and advances when the stage after it is empty or
// moving, so bubbles are squeezed out and input is taken while a result
// waits in the output register. When the receiver stalls, the output holds
// and the stages fill up behind it; in_bus.ready drops only once all five
// stages are full. Nothing is lost. Reset (rst_n low, synchronous) empties
// every stage and sets the reaction mode to 0.
module reaction_diffusion_cell_update_top
  import rdcu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rdcu_in_if.sink    in_bus,
  rdcu_out_if.source out_bus,
  rdcu_cfg_if.sink   cfg_bus
);

  rmode_t reaction_mode_r;
  logic mid_valid, mid_ready;
  blur_t mid_data;
  result_t res;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reaction_mode_r <= RMODE_STD;
    end else if (cfg_bus.valid) begin
      reaction_mode_r <= cfg_bus.reaction_mode;
    end
  end

  rdcu_blur u_blur (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_bus.valid),
    .up_ready     (in_bus.ready),
    .center_cell  (in_bus.center_cell),
    .north_cell   (in_bus.north_cell),
    .south_cell   (in_bus.south_cell),
    .east_cell    (in_bus.east_cell),
    .west_cell    (in_bus.west_cell),
    .stencil_mode (in_bus.stencil_mode),
    .dn_valid     (mid_valid),
    .dn_ready     (mid_ready),
    .dn_data      (mid_data)
  );

  rdcu_react u_react (
    .clk           (clk),
    .rst_n         (rst_n),
    .reaction_mode (reaction_mode_r),
    .up_valid      (mid_valid),
    .up_ready      (mid_ready),
    .up_data       (mid_data),
    .dn_valid      (out_bus.valid),
    .dn_ready      (out_bus.ready),
    .dn_data       (res)
  );

  assign out_bus.new_cell = res.new_cell;
  assign out_bus.display_level = res.display_level;

endmodule

// ===== src/rdcu_checker.sv =====
module rdcu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_cell,
  input logic [7:0]  out_display_level
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_cell)
      && $stable(out_display_level))
    else $error("stalled result beat changed");

  a_display: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_display_level == out_new_cell[15:8])
    else $error("display level does not match new u");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // empty output register means every stage may advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  a_fill_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_ready |=> out_valid || in_ready)
    else $error("pipeline stalled input without a result waiting");

endmodule

bind reaction_diffusion_cell_update_top rdcu_checker u_rdcu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_new_cell      (out_bus.new_cell),
  .out_display_level (out_bus.display_level)
);
